>>> src/arc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address resolution cache package
// Item types, status codes and the token and write-port structs that travel
// along the row of table cells.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int SLOT_IDX_W      = 8;   // holds any cell index up to 255
    localparam int SLOT_W          = 4;
    localparam logic [31:0] MAX_AGE_RESET = 32'd300;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_EXPIRED   = 3'd2;
    localparam logic [2:0] ST_REFRESHED = 3'd3;
    localparam logic [2:0] ST_INSERTED  = 3'd4;
    localparam logic [2:0] ST_DROPPED   = 3'd5;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] ip_addr;
        logic [47:0] hw_addr;
        logic [31:0] now_ticks;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [47:0]       mac_out;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic                  mode;
        logic [31:0]           ip_addr;
        logic [47:0]           hw_addr;
        logic [31:0]           now_ticks;
        logic                  found;
        logic                  fresh;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  free_found;
        logic [SLOT_IDX_W-1:0] free_slot;
        logic [47:0]           mac_res;
    } t_tok;

    // Insert write broadcast to all cells.
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] slot;
        logic [31:0]           ip_addr;
        logic [47:0]           hw_addr;
        logic [31:0]           stamp;
    } t_ins;

endpackage
`default_nettype wire

>>> src/arc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address resolution cache cell
// Holds one table entry, checks the passing search token against it and
// hands the token on to the next cell through its output register.
// ----------------------------------------------------------------------------
module arc_cell
    import arc_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_max_age,
    input  wire t_ins        i_ins,
    input  wire logic        i_tok_valid,
    input  wire t_tok        i_tok,
    output logic             o_tok_valid,
    output t_tok             o_tok
);

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_IDX);

    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [31:0] r_stamp;

    logic        match;
    logic [31:0] age;
    logic        fresh;
    logic        claim_free;
    logic        ins_here;
    t_tok        n_tok;

    assign match      = i_tok_valid && !i_tok.found && r_valid && (r_ip == i_tok.ip_addr);
    assign age        = i_tok.now_ticks - r_stamp;
    assign fresh      = age < i_max_age;
    assign claim_free = i_tok_valid && !r_valid && !i_tok.free_found;
    assign ins_here   = i_ins.en && (i_ins.slot == MY_IDX);

    always_comb begin
        n_tok = i_tok;
        if (match) begin
            n_tok.found = 1'b1;
            n_tok.slot  = MY_IDX;
            if (i_tok.mode == MODE_LOOKUP && fresh) begin
                n_tok.fresh   = 1'b1;
                n_tok.mac_res = r_mac;
            end
        end
        if (claim_free) begin
            n_tok.free_found = 1'b1;
            n_tok.free_slot  = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            o_tok_valid <= 1'b0;
        end else begin
            o_tok_valid <= i_tok_valid;
            if (ins_here) begin
                r_valid <= 1'b1;
            end else if (match && i_tok.mode == MODE_LOOKUP && !fresh) begin
                // A stale entry is dropped as soon as a lookup finds it.
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_tok <= n_tok;
        if (ins_here) begin
            r_ip    <= i_ins.ip_addr;
            r_mac   <= i_ins.hw_addr;
            r_stamp <= i_ins.stamp;
        end else if (match && i_tok.mode == MODE_UPDATE) begin
            r_mac   <= i_tok.hw_addr;
            r_stamp <= i_tok.now_ticks;
        end
    end

endmodule
`default_nettype wire

>>> src/address_resolution_cache_with_aging_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item is registered, its search token walks the row of cells one
// cell per cycle, and the finished token is held in a done register until
// it moves to the output register. The next item enters after that move.
// A finished result may wait in the output register while the next item runs.
// Reset (synchronous, active low) clears every valid bit and sets max_age to 300.
// ----------------------------------------------------------------------------
// Address resolution cache with aging, top level
// Fully associative IPv4 to MAC table built as a chain of entry cells, with
// refresh, insert into the lowest free slot and expiry on lookup.
// ----------------------------------------------------------------------------
module address_resolution_cache_with_aging_top
    import arc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data
);

    logic [31:0] r_max_age;
    logic        r_busy;
    logic        r_tok_valid;
    t_tok        r_tok;
    logic        r_done_valid;
    t_tok        r_done;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        tok_valid [0:TABLE_DEPTH];
    t_tok        tok       [0:TABLE_DEPTH];
    logic        in_accept;
    logic        finish;
    t_ins        ins;
    t_out_item   n_out;

    assign in_accept = i_in_valid && !r_busy;
    assign finish    = r_done_valid && (!r_out_valid || !i_out_stall);

    assign tok_valid[0] = r_tok_valid;
    assign tok[0]       = r_tok;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        arc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_max_age   (r_max_age),
            .i_ins       (ins),
            .i_tok_valid (tok_valid[g]),
            .i_tok       (tok[g]),
            .o_tok_valid (tok_valid[g+1]),
            .o_tok       (tok[g+1])
        );
    end

    // The insert decision can only be made once the token has seen every cell.
    always_comb begin
        ins.en      = finish && r_done.mode == MODE_UPDATE && !r_done.found
                      && r_done.free_found;
        ins.slot    = r_done.free_slot;
        ins.ip_addr = r_done.ip_addr;
        ins.hw_addr = r_done.hw_addr;
        ins.stamp   = r_done.now_ticks;

        n_out.mac_out = '0;
        n_out.slot    = '0;
        if (r_done.mode == MODE_LOOKUP) begin
            if (!r_done.found) begin
                n_out.status = ST_MISS;
            end else if (r_done.fresh) begin
                n_out.status  = ST_HIT;
                n_out.mac_out = r_done.mac_res;
                n_out.slot    = r_done.slot[SLOT_W-1:0];
            end else begin
                n_out.status = ST_EXPIRED;
                n_out.slot   = r_done.slot[SLOT_W-1:0];
            end
        end else if (r_done.found) begin
            n_out.status = ST_REFRESHED;
            n_out.slot   = r_done.slot[SLOT_W-1:0];
        end else if (r_done.free_found) begin
            n_out.status = ST_INSERTED;
            n_out.slot   = r_done.free_slot[SLOT_W-1:0];
        end else begin
            n_out.status = ST_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age    <= MAX_AGE_RESET;
            r_busy       <= 1'b0;
            r_tok_valid  <= 1'b0;
            r_done_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_age <= i_cfg_wr_data;
            end
            r_tok_valid <= in_accept;
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (tok_valid[TABLE_DEPTH]) begin
                r_done_valid <= 1'b1;
            end else if (finish) begin
                r_done_valid <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tok.mode       <= i_in_data.mode;
            r_tok.ip_addr    <= i_in_data.ip_addr;
            r_tok.hw_addr    <= i_in_data.hw_addr;
            r_tok.now_ticks  <= i_in_data.now_ticks;
            r_tok.found      <= 1'b0;
            r_tok.fresh      <= 1'b0;
            r_tok.slot       <= '0;
            r_tok.free_found <= 1'b0;
            r_tok.free_slot  <= '0;
            r_tok.mac_res    <= '0;
        end
        if (tok_valid[TABLE_DEPTH]) begin
            r_done <= tok[TABLE_DEPTH];
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> src/arc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address resolution cache checker
// Port-level properties of the cache, bound to the top level.
// ----------------------------------------------------------------------------
module arc_checker
    import arc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    logic unused_in;
    assign unused_in = ^i_in_data;

    // A waiting result item holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    // Only one item is searched at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted during a search");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_DROPPED)
        else $error("status code out of range");

    a_mac_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_HIT |-> o_out_data.mac_out == '0)
        else $error("MAC reported without a hit");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_MISS || o_out_data.status == ST_DROPPED)
        |-> o_out_data.slot == '0)
        else $error("slot reported on miss or drop");

endmodule

bind address_resolution_cache_with_aging_top arc_checker u_arc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
